/* sv/bfa_pkg.sv */
// Package: constants, types and helpers shared by the bitmap frame allocator.
package bfa_pkg;
	localparam int unsigned MapBlocksDef  = 32768;
	localparam int unsigned BlockBytesDef = 4096;
	localparam int unsigned WordBits      = 32;
	localparam logic [15:0] MaxBlocksRst  = 16'd32768;

	typedef enum logic [1:0] {
		OP_ALLOC   = 2'd0,
		OP_FREE    = 2'd1,
		OP_AVAIL   = 2'd2,
		OP_RESERVE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NOMEM   = 2'd1,
		ST_ZERO    = 2'd2,
		ST_CLIPPED = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		FSM_IDLE,
		FSM_SCAN,
		FSM_MARK,
		FSM_SWEEP,
		FSM_BLK0,
		FSM_DONE
	} fsm_t;

	// Mask of bits lo..hi (inclusive) in a word; empty when lo > hi.
	function automatic logic [WordBits-1:0] range_mask(input logic [4:0] lo,
	                                                   input logic [4:0] hi);
		logic [WordBits-1:0] m_lo;
		logic [WordBits-1:0] m_hi;
		m_lo = {WordBits{1'b1}} << lo;
		m_hi = {WordBits{1'b1}} >> (5'd31 - hi);
		return m_lo & m_hi;
	endfunction
endpackage

/* sv/bfa_map_ram.sv */
// Module: bitmap word memory, one write port and one registered read port.
module bfa_map_ram #(
	parameter int unsigned Words = 1024,
	parameter int unsigned AddrW = 10
) (
	input  logic                          clk,
	input  logic                          we,
	input  logic [AddrW-1:0]              waddr,
	input  logic [bfa_pkg::WordBits-1:0]  wdata,
	input  logic [AddrW-1:0]              raddr,
	output logic [bfa_pkg::WordBits-1:0]  rdata
);
	logic [bfa_pkg::WordBits-1:0] mem [Words];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end
endmodule

/* sv/bitmap_frame_allocator.sv */
// Top level: first-fit bitmap page frame allocator over a word-wide bitmap memory.
// One item at a time; each beat gets exactly one result. After reset a clearing pass writes
// all-ones to every bitmap word while no item is taken. For every word that an op touches,
// the block first issues the memory read, then uses the data (and writes back). An allocate
// scans from word 0 up to the word where the run completes or the limit ends, then rewrites
// the words of the run; free and region ops read-modify-write the words of the range;
// make-available then also marks block 0 as used. Each item ends in the done state, which
// loads the result register; a zero count or an early out-of-memory goes straight from idle
// to the done state. The result waits in its own register, so the next item is taken while
// it waits; the block only stalls at the end of that item if the earlier result is still
// not taken.
module bitmap_frame_allocator #(
	parameter int unsigned MAP_BLOCKS  = bfa_pkg::MapBlocksDef,
	parameter int unsigned BLOCK_BYTES = bfa_pkg::BlockBytesDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic [31:0] address,
	input  logic [31:0] amount,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [31:0] block_address,
	output logic [15:0] free_blocks
);
	localparam int unsigned Words = (MAP_BLOCKS + 31) / 32;
	localparam int unsigned AW    = (Words > 1) ? $clog2(Words) : 1;
	localparam int unsigned BW    = $clog2(MAP_BLOCKS + 1);   // block index/count width
	localparam int unsigned SH    = $clog2(BLOCK_BYTES);
	localparam logic [BW-1:0] MapB = BW'(MAP_BLOCKS);

	// registers
	logic [15:0]    max_q;
	logic [BW-1:0]  used_q;
	bfa_pkg::fsm_t  st_q, st_d;
	logic           clr_q;
	logic [AW-1:0]  clr_addr_q;
	logic [1:0]     op_q;
	logic [BW-1:0]  first_q;      // start block of range
	logic [BW-1:0]  last_q;       // last block of range (inclusive)
	logic [31:0]    need_q;       // requested run length
	logic [BW-1:0]  run_q;        // current free run length
	logic [BW-1:0]  lim_q;
	logic [AW:0]    wa_q;         // word being handled
	logic           rd_pend_q;    // memory data valid for wa_q
	logic           clip_q;
	logic [1:0]     res_st_q;
	logic [31:0]    res_addr_q;
	logic           out_v_q;
	logic [1:0]     out_st_q;
	logic [31:0]    out_addr_q;
	logic [15:0]    out_free_q;

	logic                          we;
	logic [AW-1:0]                 waddr, raddr;
	logic [bfa_pkg::WordBits-1:0]  wdata, rdata;

	bfa_map_ram #(.Words(Words), .AddrW(AW)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	// effective limit
	logic [BW-1:0] lim;
	assign lim = ({16'd0, max_q} < 32'(MAP_BLOCKS)) ? BW'(max_q) : MapB;

	logic [BW-1:0] free_cnt;
	assign free_cnt = (lim > used_q) ? lim - used_q : '0;

	// incoming decode
	logic [31:0] start_blk32, n_blk32, room32;
	logic        over_req;
	logic [31:0] n_eff;
	assign start_blk32 = address >> SH;
	assign n_blk32     = (op == bfa_pkg::OP_FREE) ? amount : (amount >> SH);
	assign room32      = (start_blk32 >= 32'(lim)) ? 32'd0 : 32'(lim) - start_blk32;
	assign over_req    = n_blk32 > room32;
	assign n_eff       = over_req ? room32 : n_blk32;

	// scan of one word: run length at each bit from the last used bit before it
	logic [BW-1:0]  s_run;
	logic           s_found;
	logic [BW-1:0]  s_first;
	always_comb begin
		logic [4:0]    p;
		logic          seen;
		logic [BW:0]   len;
		logic [BW:0]   b;
		p       = '0;
		seen    = 1'b0;
		len     = '0;
		s_found = 1'b0;
		s_first = '0;
		for (int i = 0; i < 32; i++) begin
			b = (BW+1)'({wa_q, 5'(i)});
			// bits at or above the limit break any run
			if (rdata[i] || b >= {1'b0, lim_q}) begin
				p    = 5'(i);
				seen = 1'b1;
			end
			if (seen)
				len = (BW+1)'(5'(i) - p);
			else
				len = {1'b0, run_q} + (BW+1)'(i + 1);
			if (!s_found && 32'(len) == need_q) begin
				s_found = 1'b1;
				s_first = BW'(b - len + 1'b1);
			end
		end
		s_run = BW'(len);
	end

	// mask of current word for range first_q..last_q
	logic [4:0]  m_lo, m_hi;
	logic [31:0] mask_w;
	logic [5:0]  mcount;
	logic        last_word;
	always_comb begin
		m_lo = (wa_q == (AW+1)'(first_q >> 5)) ? first_q[4:0] : 5'd0;
		m_hi = (wa_q == (AW+1)'(last_q >> 5)) ? last_q[4:0] : 5'd31;
		mask_w    = bfa_pkg::range_mask(m_lo, m_hi);
		mcount    = 6'(m_hi - m_lo) + 6'd1;
		last_word = wa_q == (AW+1)'(last_q >> 5);
	end

	// used count with saturation
	logic [BW:0] up_sum;
	logic [BW-1:0] cnt_up, cnt_dn;
	assign up_sum = {1'b0, used_q} + (BW+1)'(mcount);
	assign cnt_up = (up_sum > {1'b0, MapB}) ? MapB : up_sum[BW-1:0];
	assign cnt_dn = (used_q > BW'(mcount)) ? used_q - BW'(mcount) : '0;

	logic accept;
	logic done_fire;
	assign in_ready  = (st_q == bfa_pkg::FSM_IDLE) && !clr_q;
	assign accept    = in_valid && in_ready;
	assign done_fire = (st_q == bfa_pkg::FSM_DONE) && (!out_v_q || out_ready);
	assign out_valid = out_v_q;
	assign status        = out_st_q;
	assign block_address = out_addr_q;
	assign free_blocks   = out_free_q;

	// memory port drive and next state
	always_comb begin
		st_d  = st_q;
		we    = 1'b0;
		waddr = wa_q[AW-1:0];
		wdata = rdata;
		raddr = wa_q[AW-1:0];
		if (clr_q) begin
			we    = 1'b1;
			waddr = clr_addr_q;
			wdata = '1;
		end
		unique case (st_q)
			bfa_pkg::FSM_IDLE: begin
				if (accept) begin
					if ((op == bfa_pkg::OP_ALLOC || op == bfa_pkg::OP_FREE) && amount == 0)
						st_d = bfa_pkg::FSM_DONE;
					else if (op == bfa_pkg::OP_ALLOC)
						st_d = (32'(free_cnt) < amount) ? bfa_pkg::FSM_DONE : bfa_pkg::FSM_SCAN;
					else if (n_eff == 0)
						st_d = (op == bfa_pkg::OP_AVAIL) ? bfa_pkg::FSM_BLK0 : bfa_pkg::FSM_DONE;
					else
						st_d = bfa_pkg::FSM_SWEEP;
				end
			end
			bfa_pkg::FSM_SCAN: begin
				if (rd_pend_q) begin
					if (s_found) begin
						st_d = bfa_pkg::FSM_MARK;
					end else if ((32'(wa_q) + 32'd1) * 32'd32 >= 32'(lim_q)) begin
						st_d = bfa_pkg::FSM_DONE;
					end
				end
			end
			bfa_pkg::FSM_MARK, bfa_pkg::FSM_SWEEP: begin
				if (rd_pend_q) begin
					we = 1'b1;
					if (st_q == bfa_pkg::FSM_SWEEP && op_q != bfa_pkg::OP_RESERVE)
						wdata = rdata & ~mask_w;
					else
						wdata = rdata | mask_w;
					if (last_word)
						st_d = (op_q == bfa_pkg::OP_AVAIL) ? bfa_pkg::FSM_BLK0 : bfa_pkg::FSM_DONE;
				end
			end
			bfa_pkg::FSM_BLK0: begin
				raddr = '0;
				waddr = '0;
				if (rd_pend_q) begin
					we    = 1'b1;
					wdata = rdata | 32'd1;
					st_d  = bfa_pkg::FSM_DONE;
				end
			end
			bfa_pkg::FSM_DONE: begin
				if (done_fire)
					st_d = bfa_pkg::FSM_IDLE;
			end
			default: st_d = bfa_pkg::FSM_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= bfa_pkg::FSM_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	// control and datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q      <= bfa_pkg::MaxBlocksRst;
			used_q     <= MapB;
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
			rd_pend_q  <= 1'b0;
			out_v_q    <= 1'b0;
			res_st_q   <= bfa_pkg::ST_OK;
			res_addr_q <= '0;
			out_st_q   <= bfa_pkg::ST_OK;
			out_addr_q <= '0;
			out_free_q <= '0;
		end else begin
			if (cfg_we) max_q <= cfg_wdata;
			// clearing pass
			if (clr_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (32'(clr_addr_q) == Words - 1) clr_q <= 1'b0;
			end
			// result beat handshake
			if (done_fire)
				out_v_q <= 1'b1;
			else if (out_ready)
				out_v_q <= 1'b0;

			unique case (st_q)
				bfa_pkg::FSM_IDLE: begin
					rd_pend_q <= 1'b0;
					if (accept) begin
						op_q       <= op;
						lim_q      <= lim;
						need_q     <= amount;
						run_q      <= '0;
						res_addr_q <= '0;
						first_q    <= BW'(start_blk32);
						last_q     <= BW'(start_blk32 + n_eff - 32'd1);
						clip_q     <= over_req && (op != bfa_pkg::OP_ALLOC);
						wa_q       <= (st_d == bfa_pkg::FSM_SWEEP) ?
						              (AW+1)'(start_blk32 >> 5) : '0;
						if ((op == bfa_pkg::OP_ALLOC || op == bfa_pkg::OP_FREE) && amount == 0)
							res_st_q <= bfa_pkg::ST_ZERO;
						else if (op == bfa_pkg::OP_ALLOC && 32'(free_cnt) < amount)
							res_st_q <= bfa_pkg::ST_NOMEM;
						else
							res_st_q <= bfa_pkg::ST_OK;
					end
				end
				bfa_pkg::FSM_SCAN: begin
					rd_pend_q <= !rd_pend_q;
					if (rd_pend_q) begin
						run_q <= s_run;
						if (s_found) begin
							first_q <= s_first;
							last_q  <= BW'(32'(s_first) + need_q - 32'd1);
							wa_q    <= (AW+1)'(s_first >> 5);
							res_addr_q <= 32'(s_first) << SH;
						end else begin
							wa_q <= wa_q + 1'b1;
							if (st_d == bfa_pkg::FSM_DONE) res_st_q <= bfa_pkg::ST_NOMEM;
						end
					end
				end
				bfa_pkg::FSM_MARK, bfa_pkg::FSM_SWEEP: begin
					rd_pend_q <= !rd_pend_q;
					if (rd_pend_q) begin
						wa_q <= wa_q + 1'b1;
						if (st_q == bfa_pkg::FSM_SWEEP && op_q == bfa_pkg::OP_FREE ||
						    st_q == bfa_pkg::FSM_SWEEP && op_q == bfa_pkg::OP_AVAIL)
							used_q <= cnt_dn;
						else
							used_q <= cnt_up;
					end
				end
				bfa_pkg::FSM_BLK0: begin
					rd_pend_q <= !rd_pend_q;
				end
				bfa_pkg::FSM_DONE: begin
					rd_pend_q <= 1'b0;
					// load the result register
					if (done_fire) begin
						out_st_q   <= (clip_q && op_q != bfa_pkg::OP_ALLOC) ?
						              bfa_pkg::ST_CLIPPED : res_st_q;
						out_addr_q <= res_addr_q;
						out_free_q <= 16'(free_cnt);
					end
				end
				default: ;
			endcase
		end
	end

	// result is only raised after the work ends
	a_out_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_v_q) |-> $past(st_q) == bfa_pkg::FSM_DONE)
		else $error("result raised outside done");
	// no item accepted during clearing
	a_no_acc_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_q |-> !in_ready) else $error("accept during clear");
	// used count never exceeds map size
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= MapB) else $error("used count overflow");
endmodule

/* test/bfa_checker.sv */
// Checker for the bitmap frame allocator: tracks the bitmap, predicts each result, compares.
`timescale 1ns / 1ps

module bfa_checker #(
	parameter int unsigned MAP_BLOCKS  = bfa_pkg::MapBlocksDef,
	parameter int unsigned BLOCK_BYTES = bfa_pkg::BlockBytesDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  op,
	input  logic [31:0] address,
	input  logic [31:0] amount,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [1:0]  status,
	input  logic [31:0] block_address,
	input  logic [15:0] free_blocks,
	output int          fail_count,
	output int          pending
);
	typedef struct packed {
		bfa_pkg::status_t status;
		logic [31:0]      block_address;
		logic [15:0]      free_blocks;
	} alloc_result_t;

	// Model state: 1 = block used
	bit            frame_used [MAP_BLOCKS];
	int unsigned   used_blocks;
	logic [15:0]   managed_blocks;
	alloc_result_t expected_results [$];
	int            fails;

	assign fail_count = fails;

	function automatic int unsigned limit_of();
		return (managed_blocks < MAP_BLOCKS) ? managed_blocks : MAP_BLOCKS;
	endfunction

	function automatic logic [15:0] free_now();
		int unsigned lim;
		lim = limit_of();
		return (lim > used_blocks) ? 16'(lim - used_blocks) : 16'd0;
	endfunction

	// Mark a block range, clipped at the limit; returns 1 when clipped.
	function automatic bit mark_range(input longint unsigned first, input longint unsigned n,
	                                  input bit used);
		longint unsigned room;
		bit              clipped;
		room    = (first >= limit_of()) ? 0 : limit_of() - first;
		clipped = (n > room);
		if (clipped)
			n = room;
		for (longint unsigned i = 0; i < n; i++) begin
			frame_used[first + i] = used;
			if (used) begin
				if (used_blocks < MAP_BLOCKS)
					used_blocks++;
			end else if (used_blocks > 0) begin
				used_blocks--;
			end
		end
		return clipped;
	endfunction

	function automatic alloc_result_t run_allocator_op(input bfa_pkg::op_t code,
	                                                   input logic [31:0] addr,
	                                                   input logic [31:0] cnt);
		alloc_result_t   res;
		int unsigned     first_blk;
		int unsigned     run_len;
		bit              found;
		int unsigned     start;
		res.status        = bfa_pkg::ST_OK;
		res.block_address = '0;
		start             = addr / BLOCK_BYTES;
		found             = 0;
		first_blk         = 0;
		run_len           = 0;
		case (code)
			bfa_pkg::OP_ALLOC: begin
				if (cnt == 0)
					res.status = bfa_pkg::ST_ZERO;
				else if (free_now() < cnt)
					res.status = bfa_pkg::ST_NOMEM;
				else begin
					// first fit: lowest run of cnt free blocks below the limit
					for (int unsigned b = 0; b < limit_of() && !found; b++) begin
						if (frame_used[b])
							run_len = 0;
						else begin
							run_len++;
							if (run_len == cnt) begin
								first_blk = b + 1 - cnt;
								found     = 1;
							end
						end
					end
					if (!found)
						res.status = bfa_pkg::ST_NOMEM;
					else begin
						void'(mark_range(first_blk, cnt, 1'b1));
						res.block_address = 32'(longint'(first_blk) * BLOCK_BYTES);
					end
				end
			end
			bfa_pkg::OP_FREE: begin
				if (cnt == 0)
					res.status = bfa_pkg::ST_ZERO;
				else if (mark_range(start, cnt, 1'b0))
					res.status = bfa_pkg::ST_CLIPPED;
			end
			default: begin
				if (mark_range(start, cnt / BLOCK_BYTES, code == bfa_pkg::OP_RESERVE))
					res.status = bfa_pkg::ST_CLIPPED;
				// block 0 stays used so no allocation returns address 0
				if (code == bfa_pkg::OP_AVAIL)
					frame_used[0] = 1'b1;
			end
		endcase
		res.free_blocks = free_now();
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		alloc_result_t want;
		if (!arst_n) begin
			foreach (frame_used[i])
				frame_used[i] = 1'b1;
			used_blocks    = MAP_BLOCKS;
			managed_blocks = bfa_pkg::MaxBlocksRst;
			expected_results.delete();
			fails = 0;
		end else begin
			if (cfg_we)
				managed_blocks = cfg_wdata;
			if (in_valid && in_ready)
				expected_results.push_back(run_allocator_op(bfa_pkg::op_t'(op), address,
					amount));
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$error("result beat with no expectation pending");
					fails++;
				end else begin
					want = expected_results.pop_front();
					if (status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, status);
						fails++;
					end
					if (block_address !== want.block_address) begin
						$error("block_address: expected %h, got %h", want.block_address,
							block_address);
						fails++;
					end
					if (free_blocks !== want.free_blocks) begin
						$error("free_blocks: expected %0d, got %0d", want.free_blocks,
							free_blocks);
						fails++;
					end
				end
			end
		end
		pending = expected_results.size();
	end
endmodule

/* test/bitmap_frame_allocator_tb.sv */
// Testbench top: stimulus, stall control and verdict for the bitmap frame allocator.
`timescale 1ns / 1ps

module bitmap_frame_allocator_tb;
	localparam int unsigned PageBytes  = bfa_pkg::BlockBytesDef;
	localparam int          StallLimit = 60000;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [15:0] cfg_wdata;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  op;
	logic [31:0] address;
	logic [31:0] amount;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  status;
	logic [31:0] block_address;
	logic [15:0] free_blocks;
	int          fail_count;
	int          pending;

	int          send_idle_pct;
	int          recv_idle_pct;
	int unsigned cur_limit;
	int          items_sent;
	int          quiet_cycles;

	bitmap_frame_allocator i_dut (
		.clk, .arst_n, .cfg_we, .cfg_wdata,
		.in_valid, .in_ready, .op, .address, .amount,
		.out_valid, .out_ready, .status, .block_address, .free_blocks
	);

	bfa_checker i_checker (
		.clk, .arst_n, .cfg_we, .cfg_wdata,
		.in_valid, .in_ready, .op, .address, .amount,
		.out_valid, .out_ready, .status, .block_address, .free_blocks,
		.fail_count, .pending
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Receiver stalls at random
	always @(negedge clk)
		out_ready <= ($urandom_range(99) >= recv_idle_pct);

	// Watchdog on cycles with no beat on either channel
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= StallLimit) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	task automatic send_beat(input bfa_pkg::op_t code, input logic [31:0] addr,
	                         input logic [31:0] cnt);
		@(negedge clk);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do
				@(negedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		op       <= code;
		address  <= addr;
		amount   <= cnt;
		do
			@(posedge clk);
		while (!in_ready);
		items_sent++;
	endtask

	// Register write once all results are back
	task automatic set_limit(input logic [15:0] value);
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we    <= 1'b0;
		cur_limit = (value < bfa_pkg::MapBlocksDef) ? value : bfa_pkg::MapBlocksDef;
	endtask

	// Mostly in-range, small-count ops; some full-width noise
	task automatic send_random(input int count);
		bfa_pkg::op_t code;
		logic [31:0]  addr;
		logic [31:0]  cnt;
		int           pick;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(99);
			code = (pick < 35) ? bfa_pkg::OP_ALLOC : (pick < 60) ? bfa_pkg::OP_FREE :
			       (pick < 85) ? bfa_pkg::OP_AVAIL : bfa_pkg::OP_RESERVE;
			if ($urandom_range(9) == 0)
				addr = $urandom;
			else
				addr = $urandom_range(cur_limit + 8) * PageBytes + $urandom_range(PageBytes - 1);
			pick = $urandom_range(19);
			if (pick == 0)
				cnt = 0;
			else if (pick == 1)
				cnt = $urandom;
			else if (code inside {bfa_pkg::OP_ALLOC, bfa_pkg::OP_FREE})
				cnt = $urandom_range(16, 1);
			else
				cnt = $urandom_range(48) * PageBytes + $urandom_range(PageBytes - 1);
			send_beat(code, addr, cnt);
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_wdata     = '0;
		in_valid      = 1'b0;
		op            = bfa_pkg::OP_ALLOC;
		address       = '0;
		amount        = '0;
		out_ready     = 1'b0;
		items_sent    = 0;
		quiet_cycles  = 0;
		cur_limit     = bfa_pkg::MapBlocksDef;
		send_idle_pct = 17;
		recv_idle_pct = 69;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: everything used at reset, so these start out of memory
		send_beat(bfa_pkg::OP_ALLOC, 32'd0, 32'd1);
		send_beat(bfa_pkg::OP_ALLOC, 32'd0, 32'd0);
		send_beat(bfa_pkg::OP_FREE, 32'h1000, 32'd0);
		send_beat(bfa_pkg::OP_AVAIL, 32'd0, 32'd64 * PageBytes);
		send_beat(bfa_pkg::OP_ALLOC, 32'hdead_beef, 32'd1);
		send_beat(bfa_pkg::OP_ALLOC, 32'd0, 32'd5);
		send_beat(bfa_pkg::OP_ALLOC, 32'd0, 32'd70);
		send_beat(bfa_pkg::OP_FREE, 32'h1fff, 32'd1);
		send_beat(bfa_pkg::OP_ALLOC, 32'd0, 32'd1);
		// double reserve and double free
		send_beat(bfa_pkg::OP_RESERVE, 32'd2 * PageBytes, 32'd3 * PageBytes);
		send_beat(bfa_pkg::OP_RESERVE, 32'd2 * PageBytes, 32'd3 * PageBytes);
		send_beat(bfa_pkg::OP_FREE, 32'd10 * PageBytes, 32'd2);
		send_beat(bfa_pkg::OP_FREE, 32'd10 * PageBytes, 32'd2);
		// empty region and clipping at the top
		send_beat(bfa_pkg::OP_AVAIL, 32'd5 * PageBytes, PageBytes - 1);
		send_beat(bfa_pkg::OP_AVAIL, 32'hffff_f000, 32'hffff_ffff);
		send_beat(bfa_pkg::OP_FREE, 32'd32767 * PageBytes, 32'd5);
		send_beat(bfa_pkg::OP_RESERVE, 32'hffff_ffff, 32'hffff_ffff);
		// free everything, take the whole map, reserve it all
		send_beat(bfa_pkg::OP_FREE, 32'd0, 32'hffff_ffff);
		send_beat(bfa_pkg::OP_ALLOC, 32'd0, 32'hffff_ffff);
		send_beat(bfa_pkg::OP_ALLOC, 32'd0, bfa_pkg::MapBlocksDef);
		send_beat(bfa_pkg::OP_RESERVE, 32'd0, bfa_pkg::MapBlocksDef * PageBytes);
		// enough free blocks but no contiguous run
		send_beat(bfa_pkg::OP_AVAIL, 32'd0, 32'd8 * PageBytes);
		send_beat(bfa_pkg::OP_RESERVE, 32'd3 * PageBytes, PageBytes);
		send_beat(bfa_pkg::OP_ALLOC, 32'd0, 32'd5);
		send_beat(bfa_pkg::OP_AVAIL, 32'd0, bfa_pkg::MapBlocksDef * PageBytes);

		set_limit(16'hffff);
		send_random(100);
		set_limit(16'd0);
		send_random(30);

		send_idle_pct = 69;
		recv_idle_pct = 17;
		set_limit(16'd300);
		send_random(150);
		set_limit(16'd32768);
		send_random(150);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		set_limit(16'd40);
		send_random(150);

		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		$display("Ran %0d allocate/free/region ops over limits 32768, 65535, 0, 300 and 40,",
			items_sent);
		$display("with sender and receiver stalls in both orders and with none.");
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule

/* filelist.f */
sv/bfa_pkg.sv
sv/bfa_map_ram.sv
sv/bitmap_frame_allocator.sv
test/bfa_checker.sv
test/bitmap_frame_allocator_tb.sv
